>>> design/tks_pkg.sv
`timescale 1ns / 1ps

package tks_pkg;

  // Position counter wraps at TEXT_LEN; the low 16 bits are reported.
  localparam int unsigned TEXT_LEN = 65536;
  localparam int unsigned POS_W    = $clog2(TEXT_LEN);

  localparam int unsigned KIND_W = 3;
  localparam int unsigned CODE_W = 4;
  localparam int unsigned LEN_W  = 16;

  localparam logic [KIND_W-1:0] KIND_OP  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_KEY = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ID  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DEC = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OCT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_HEX = 3'd5;
  localparam logic [KIND_W-1:0] KIND_ERR = 3'd6;
  localparam logic [KIND_W-1:0] KIND_END = 3'd7;

  localparam logic [CODE_W-1:0] CODE_NONE    = 4'd0;
  localparam logic [CODE_W-1:0] ERR_UNKNOWN  = 4'd0;
  localparam logic [CODE_W-1:0] ERR_BAD_HEX  = 4'd1;
  localparam logic [CODE_W-1:0] ERR_BAD_ZERO = 4'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  start;
    logic [LEN_W-1:0]  length;
    logic              last;
  } tks_res_t;

  // Up to two results from one character: a flushed pending token first,
  // then whatever the character produces on its own.
  typedef struct packed {
    logic     a_vld;
    tks_res_t a;
    logic     b_vld;
    tks_res_t b;
  } tks_pair_t;

endpackage

>>> design/token_scanner.sv
// token_scanner: one character per transaction in, tokens out.
// Path: a character is held in the input register, and its results are then
//   written into the result queue, which offers them to the consumer.
// Throughput: one character per cycle while the queue has room; a character
//   that yields two tokens fills two queue entries, each taken separately, and
//   the input stalls once the result queue holds three or more tokens.
`timescale 1ns / 1ps

module token_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_token_kind,
  output logic [3:0]  out_token_code,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic        out_run_last
);

  // Reset (rst_n low, synchronous): scanner idle, position zero, queue empty.

  // Input register: one character waiting for the scanner.
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_ch_r;
  logic       in_take;

  // Scanner advances when a character is held and the queue can take two.
  logic               room;
  logic               step;
  logic               pop;
  tks_pkg::tks_pair_t pair;
  tks_pkg::tks_res_t  res;

  assign step     = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take)   in_vld_nxt = 1'b1;
    else if (step) in_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_take) in_ch_r <= in_ch;
  end

  // Token state machine: flush of the pending token plus the character's own.
  tks_lexer u_lexer (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .ch    (in_ch_r),
    .pair  (pair)
  );

  // Output side: result queue decouples the scanner from the consumer.
  assign pop = out_valid && !out_stall;

  tks_res_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (step),
    .pair    (pair),
    .room    (room),
    .out_vld (out_valid),
    .pop     (pop),
    .out_res (res)
  );

  assign out_token_kind   = res.kind;
  assign out_token_code   = res.code;
  assign out_token_start  = res.start;
  assign out_token_length = res.length;
  assign out_run_last     = res.last;

endmodule

>>> design/tks_lexer.sv
`timescale 1ns / 1ps

module tks_lexer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        ch,
  output tks_pkg::tks_pair_t pair
);

  typedef enum logic [2:0] {
    M_IDLE, M_ALPHA, M_IDENT, M_ZERO, M_DEC, M_OCT, M_ZX, M_HEX
  } mode_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } kw_t;

  mode_t                     mode_r, mode_nxt;
  logic [tks_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]               start_r, start_nxt;
  logic [15:0]               len_r, len_nxt;
  logic [39:0]               letters_r, letters_nxt;
  logic [2:0]                cnt_r, cnt_nxt;

  logic       is_letter, is_digit, is_hexd, is_oct, is_sep;
  logic       fresh;
  logic [15:0] pos16;
  kw_t        kw;
  logic       op_hit;
  logic [3:0] op_idx;
  logic       a_vld, b_vld;
  tks_pkg::tks_res_t a, b;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction

  function automatic kw_t kw_match(input logic [39:0] l, input logic [2:0] n);
    kw_t k;
    k = '{hit: 1'b1, idx: 4'd0};
    if (n == 3'd2 && l == 40'h0000006966)      k.idx = 4'd0;  // if
    else if (n == 3'd4 && l == 40'h007468656E) k.idx = 4'd1;  // then
    else if (n == 3'd4 && l == 40'h00656C7365) k.idx = 4'd2;  // else
    else if (n == 3'd5 && l == 40'h7768696C65) k.idx = 4'd3;  // while
    else if (n == 3'd2 && l == 40'h000000646F) k.idx = 4'd4;  // do
    else                                       k.hit = 1'b0;
    return k;
  endfunction

  assign is_letter = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
  assign is_digit  = (ch >= 8'h30 && ch <= 8'h39);
  assign is_hexd   = is_digit || (ch >= 8'h61 && ch <= 8'h66);
  assign is_oct    = (ch >= 8'h30 && ch <= 8'h37);
  assign is_sep    = (ch == 8'h20) || (ch == 8'h0A) || (ch == 8'h09);
  assign pos16     = 16'(pos_r);
  assign kw        = kw_match(letters_r, cnt_r);

  always_comb begin
    op_hit = 1'b1;
    op_idx = 4'd0;
    unique case (ch)
      8'h2B:   op_idx = 4'd0;   // +
      8'h2D:   op_idx = 4'd1;   // -
      8'h2A:   op_idx = 4'd2;   // *
      8'h2F:   op_idx = 4'd3;   // /
      8'h3E:   op_idx = 4'd4;   // >
      8'h3C:   op_idx = 4'd5;   // <
      8'h3D:   op_idx = 4'd6;   // =
      8'h28:   op_idx = 4'd7;   // (
      8'h29:   op_idx = 4'd8;   // )
      8'h3B:   op_idx = 4'd9;   // ;
      8'h7C:   op_idx = 4'd10;  // |
      default: op_hit = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt    = mode_r;
    start_nxt   = start_r;
    len_nxt     = len_r;
    letters_nxt = letters_r;
    cnt_nxt     = cnt_r;
    pos_nxt     = (pos_r == tks_pkg::POS_W'(tks_pkg::TEXT_LEN - 1)) ? '0
                : pos_r + tks_pkg::POS_W'(1);
    fresh       = 1'b1;
    a_vld       = 1'b0;
    a           = '{kind: tks_pkg::KIND_ID, code: tks_pkg::CODE_NONE,
                    start: start_r, length: len_r, last: 1'b0};
    b_vld       = 1'b0;
    b           = '{kind: tks_pkg::KIND_ERR, code: tks_pkg::ERR_UNKNOWN,
                    start: pos16, length: 16'd1, last: 1'b1};

    // Pending token: extend it or flush it.
    unique case (mode_r)
      M_ALPHA: begin
        if (is_letter) begin
          if (cnt_r < 3'd5) letters_nxt = {letters_r[31:0], ch};
          if (cnt_r < 3'd6) cnt_nxt = cnt_r + 3'd1;
          len_nxt = sat_inc(len_r);
          fresh   = 1'b0;
        end else if (is_digit && !kw.hit) begin
          mode_nxt = M_IDENT;
          len_nxt  = sat_inc(len_r);
          fresh    = 1'b0;
        end else begin
          a_vld = 1'b1;
          if (kw.hit) begin
            a.kind = tks_pkg::KIND_KEY;
            a.code = kw.idx;
          end
        end
      end
      M_IDENT: begin
        if (is_letter || is_digit) begin
          len_nxt = sat_inc(len_r);
          fresh   = 1'b0;
        end else begin
          a_vld = 1'b1;
        end
      end
      M_ZERO: begin
        if (ch == 8'h78) begin
          mode_nxt = M_ZX;
          len_nxt  = 16'd2;
          fresh    = 1'b0;
        end else if (is_oct && ch != 8'h30) begin
          mode_nxt    = M_OCT;
          start_nxt   = pos16;
          len_nxt     = 16'd1;
          letters_nxt = '0;
          cnt_nxt     = '0;
          fresh       = 1'b0;
        end else begin
          a_vld    = 1'b1;
          a.length = 16'd1;
          if (is_digit) begin
            a.kind = tks_pkg::KIND_ERR;
            a.code = tks_pkg::ERR_BAD_ZERO;
          end else begin
            a.kind = tks_pkg::KIND_DEC;
          end
        end
      end
      M_DEC: begin
        if (is_digit) begin
          len_nxt = sat_inc(len_r);
          fresh   = 1'b0;
        end else begin
          a_vld  = 1'b1;
          a.kind = tks_pkg::KIND_DEC;
        end
      end
      M_OCT: begin
        if (is_oct) begin
          len_nxt = sat_inc(len_r);
          fresh   = 1'b0;
        end else begin
          a_vld  = 1'b1;
          a.kind = tks_pkg::KIND_OCT;
        end
      end
      M_ZX: begin
        if (is_hexd) begin
          mode_nxt    = M_HEX;
          start_nxt   = pos16;
          len_nxt     = 16'd1;
          letters_nxt = '0;
          cnt_nxt     = '0;
          fresh       = 1'b0;
        end else begin
          a_vld    = 1'b1;
          a.kind   = tks_pkg::KIND_ERR;
          a.code   = tks_pkg::ERR_BAD_HEX;
          a.length = 16'd2;
        end
      end
      M_HEX: begin
        if (is_hexd) begin
          len_nxt = sat_inc(len_r);
          fresh   = 1'b0;
        end else begin
          a_vld  = 1'b1;
          a.kind = tks_pkg::KIND_HEX;
        end
      end
      M_IDLE: begin
      end
      default: begin
      end
    endcase

    // Character not absorbed by the pending token: scan it on its own.
    if (fresh) begin
      mode_nxt = M_IDLE;
      if (ch == 8'h23) begin
        // end of text: emit end token and return to reset state
        b_vld       = 1'b1;
        b.kind      = tks_pkg::KIND_END;
        b.code      = tks_pkg::CODE_NONE;
        b.length    = 16'd0;
        pos_nxt     = '0;
        start_nxt   = '0;
        len_nxt     = '0;
        letters_nxt = '0;
        cnt_nxt     = '0;
      end else if (is_sep) begin
      end else if (is_letter) begin
        mode_nxt    = M_ALPHA;
        start_nxt   = pos16;
        len_nxt     = 16'd1;
        letters_nxt = {32'd0, ch};
        cnt_nxt     = 3'd1;
      end else if (is_digit) begin
        mode_nxt    = (ch == 8'h30) ? M_ZERO : M_DEC;
        start_nxt   = pos16;
        len_nxt     = 16'd1;
        letters_nxt = '0;
        cnt_nxt     = '0;
      end else begin
        b_vld = 1'b1;
        if (op_hit) begin
          b.kind = tks_pkg::KIND_OP;
          b.code = op_idx;
        end
      end
    end

    a.last = !b_vld;
  end

  assign pair = '{a_vld: a_vld, a: a, b_vld: b_vld, b: b};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_IDLE;
      pos_r     <= '0;
      start_r   <= '0;
      len_r     <= '0;
      letters_r <= '0;
      cnt_r     <= '0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      pos_r     <= pos_nxt;
      start_r   <= start_nxt;
      len_r     <= len_nxt;
      letters_r <= letters_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

>>> design/tks_res_fifo.sv
`timescale 1ns / 1ps

// Four-entry result queue; takes up to two results per cycle, gives one.
module tks_res_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tks_pkg::tks_pair_t pair,
  output logic               room,
  output logic               out_vld,
  input  logic               pop,
  output tks_pkg::tks_res_t  out_res
);

  tks_pkg::tks_res_t mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic [1:0] n_push;
  logic [1:0] wr_ptr_p1;
  tks_pkg::tks_res_t first, second;

  assign room      = (count_r <= 3'd2);
  assign out_vld   = (count_r != 3'd0);
  assign out_res   = mem_r[rd_ptr_r];
  assign wr_ptr_p1 = wr_ptr_r + 2'd1;

  always_comb begin
    n_push = push ? (2'(pair.a_vld) + 2'(pair.b_vld)) : 2'd0;
    first  = pair.a_vld ? pair.a : pair.b;
    second = pair.b;
    wr_ptr_nxt = wr_ptr_r + n_push;
    rd_ptr_nxt = rd_ptr_r + 2'(pop);
    count_nxt  = count_r + 3'(n_push) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem_r[wr_ptr_r] <= first;
    if (n_push == 2'd2) mem_r[wr_ptr_p1] <= second;
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // Scanner modes of the predictor; the block keeps its own encoding.
  typedef enum logic [2:0] {
    SM_IDLE, SM_ALPHA, SM_IDENT, SM_ZERO, SM_DEC, SM_OCT, SM_ZX, SM_HEX
  } scan_state_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_ch = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_token_kind;
  logic [3:0]  out_token_code;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic        out_run_last;

  token_scanner dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ch            (in_ch),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_token_code   (out_token_code),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_run_last     (out_run_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Operator code = index into this string; keyword code = index into the array.
  string op_chars = "+-*/><=();|";
  string keyword_text[5] = '{"if", "then", "else", "while", "do"};

  // Predictor state.
  scan_state_t scan_state;
  logic [15:0] pos_cnt;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  logic [39:0] letters;      // first five letters of an alphabetic run
  logic [2:0]  n_letters;    // saturates at 6

  tks_pkg::tks_res_t expected_tokens[$];
  tks_pkg::tks_res_t want_tok;
  logic [7:0] char_q[$];

  int chars_queued   = 0;
  int chars_accepted = 0;
  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // ---------------------------------------------------------------------------
  // Character classes and small helpers
  // ---------------------------------------------------------------------------
  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_hex_digit(logic [7:0] c);
    return is_num(c) || (c >= "a" && c <= "f");
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == " " || c == "\n" || c == "\t";
  endfunction

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic tks_pkg::tks_res_t tok(logic [tks_pkg::KIND_W-1:0] kind,
                                            logic [tks_pkg::CODE_W-1:0] code,
                                            logic [15:0] start, logic [15:0] len);
    tks_pkg::tks_res_t t;
    t.kind   = kind;
    t.code   = code;
    t.start  = start;
    t.length = len;
    t.last   = 1'b0;
    return t;
  endfunction

  // -1 when the run is not a keyword. Only the first five letters are kept,
  // so the letter count must match too.
  function automatic int keyword_of(logic [39:0] seen, logic [2:0] count);
    logic [39:0] kw_bytes;
    for (int k = 0; k < $size(keyword_text); k++) begin
      kw_bytes = '0;
      for (int j = 0; j < keyword_text[k].len(); j++)
        kw_bytes = {kw_bytes[31:0], keyword_text[k][j]};
      if (count == keyword_text[k].len() && kw_bytes == seen) return k;
    end
    return -1;
  endfunction

  function automatic int op_index(logic [7:0] c);
    for (int i = 0; i < op_chars.len(); i++)
      if (op_chars[i] == c) return i;
    return -1;
  endfunction

  task automatic take_letter(logic [7:0] c);
    if (n_letters < 3'd5) letters = {letters[31:0], c};
    if (n_letters < 3'd6) n_letters = n_letters + 3'd1;
  endtask

  task automatic open_token(scan_state_t m, logic [15:0] p);
    scan_state = m;
    tok_start  = p;
    tok_len    = 16'd1;
    letters    = '0;
    n_letters  = '0;
  endtask

  task automatic clear_scan();
    scan_state = SM_IDLE;
    pos_cnt    = '0;
    tok_start  = '0;
    tok_len    = '0;
    letters    = '0;
    n_letters  = '0;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor: one accepted character in, its tokens appended to
  // expected_tokens. A pending token is flushed first, then the character is
  // scanned on its own unless it extended the pending token.
  // ---------------------------------------------------------------------------
  task automatic scan_char(logic [7:0] c);
    tks_pkg::tks_res_t found[$];
    logic [15:0] here;
    bit          fresh;
    bit          text_end;
    int          kw;
    int          op;
    here     = pos_cnt;
    fresh    = 1'b1;
    text_end = 1'b0;
    case (scan_state)
      SM_ALPHA: begin
        if (is_alpha(c)) begin
          take_letter(c);
          tok_len = sat_inc(tok_len);
          fresh = 1'b0;
        end else if (is_num(c) && keyword_of(letters, n_letters) < 0) begin
          // digit after a non-keyword run: identifier
          scan_state = SM_IDENT;
          tok_len = sat_inc(tok_len);
          fresh = 1'b0;
        end else begin
          kw = keyword_of(letters, n_letters);
          if (kw >= 0)
            found.push_back(tok(tks_pkg::KIND_KEY, kw[tks_pkg::CODE_W-1:0],
                                tok_start, tok_len));
          else
            found.push_back(tok(tks_pkg::KIND_ID, tks_pkg::CODE_NONE, tok_start, tok_len));
        end
      end
      SM_IDENT: begin
        if (is_alpha(c) || is_num(c)) begin
          tok_len = sat_inc(tok_len);
          fresh = 1'b0;
        end else begin
          found.push_back(tok(tks_pkg::KIND_ID, tks_pkg::CODE_NONE, tok_start, tok_len));
        end
      end
      SM_ZERO: begin
        if (c == "x") begin
          scan_state = SM_ZX;
          tok_len = 16'd2;
          fresh = 1'b0;
        end else if (c >= "1" && c <= "7") begin
          open_token(SM_OCT, here);   // leading zero dropped
          fresh = 1'b0;
        end else if (is_num(c)) begin
          found.push_back(tok(tks_pkg::KIND_ERR, tks_pkg::ERR_BAD_ZERO, tok_start, 16'd1));
        end else begin
          found.push_back(tok(tks_pkg::KIND_DEC, tks_pkg::CODE_NONE, tok_start, 16'd1));
        end
      end
      SM_DEC: begin
        if (is_num(c)) begin
          tok_len = sat_inc(tok_len);
          fresh = 1'b0;
        end else begin
          found.push_back(tok(tks_pkg::KIND_DEC, tks_pkg::CODE_NONE, tok_start, tok_len));
        end
      end
      SM_OCT: begin
        if (c >= "0" && c <= "7") begin
          tok_len = sat_inc(tok_len);
          fresh = 1'b0;
        end else begin
          found.push_back(tok(tks_pkg::KIND_OCT, tks_pkg::CODE_NONE, tok_start, tok_len));
        end
      end
      SM_ZX: begin
        if (is_hex_digit(c)) begin
          open_token(SM_HEX, here);   // "0x" dropped
          fresh = 1'b0;
        end else begin
          found.push_back(tok(tks_pkg::KIND_ERR, tks_pkg::ERR_BAD_HEX, tok_start, 16'd2));
        end
      end
      SM_HEX: begin
        if (is_hex_digit(c)) begin
          tok_len = sat_inc(tok_len);
          fresh = 1'b0;
        end else begin
          found.push_back(tok(tks_pkg::KIND_HEX, tks_pkg::CODE_NONE, tok_start, tok_len));
        end
      end
      default: ;
    endcase

    if (fresh) begin
      scan_state = SM_IDLE;
      if (c == "#") begin
        found.push_back(tok(tks_pkg::KIND_END, tks_pkg::CODE_NONE, here, 16'd0));
        clear_scan();                 // next text counts from zero
        text_end = 1'b1;
      end else if (is_space(c)) begin
        // separator only
      end else if (is_alpha(c)) begin
        open_token(SM_ALPHA, here);
        take_letter(c);
      end else if (c == "0") begin
        open_token(SM_ZERO, here);
      end else if (is_num(c)) begin
        open_token(SM_DEC, here);
      end else begin
        op = op_index(c);
        if (op >= 0)
          found.push_back(tok(tks_pkg::KIND_OP, op[tks_pkg::CODE_W-1:0], here, 16'd1));
        else
          found.push_back(tok(tks_pkg::KIND_ERR, tks_pkg::ERR_UNKNOWN, here, 16'd1));
      end
    end

    if (!text_end) pos_cnt = pos_cnt + 16'd1;   // wraps at 64K
    if (found.size() != 0) found[found.size()-1].last = 1'b1;
    foreach (found[i]) expected_tokens.push_back(found[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0d, expected %0d (token at %0d)",
                                name, got, want, want_tok.start));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_char(logic [7:0] c);
    char_q.push_back(c);
    chars_queued++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 3) == 0) return 8'("A" + $urandom_range(0, 25));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit(int hi);
    return 8'("0" + $urandom_range(0, hi));
  endfunction

  function automatic logic [7:0] rand_hex();
    int n;
    n = $urandom_range(0, 15);
    return (n < 10) ? 8'("0" + n) : 8'("a" + n - 10);
  endfunction

  // One lexeme, mostly well formed, then maybe a separator. The tail of
  // some branches sometimes breaks the token to reach the error paths.
  task automatic add_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      push_text(keyword_text[$urandom_range(0, $size(keyword_text) - 1)]);
      case ($urandom_range(0, 5))
        0, 1: push_char(rand_digit(9));   // keyword then number
        2:    push_char(rand_letter());   // becomes identifier
        default: ;
      endcase
    end else if (pick < 30) begin
      push_char(rand_letter());
      repeat ($urandom_range(0, 8))
        push_char(($urandom_range(0, 3) == 0) ? rand_digit(9) : rand_letter());
    end else if (pick < 42) begin
      push_char(8'("1" + $urandom_range(0, 8)));
      repeat ($urandom_range(0, 4)) push_char(rand_digit(9));
    end else if (pick < 52) begin
      push_char("0");
      push_char(8'("1" + $urandom_range(0, 6)));
      repeat ($urandom_range(0, 3)) push_char(rand_digit(7));
      if ($urandom_range(0, 3) == 0) push_char(8'("8" + $urandom_range(0, 1)));
    end else if (pick < 62) begin
      push_text("0x");
      repeat ($urandom_range(1, 5)) push_char(rand_hex());
      if ($urandom_range(0, 4) == 0) push_char(8'("A" + $urandom_range(0, 5)));
    end else if (pick < 67) begin
      push_char("0");
      case ($urandom_range(0, 3))
        0: push_char("0");
        1: push_char("8");
        2: push_char("9");
        default: ;
      endcase
    end else if (pick < 72) begin
      push_text("0x");
      if ($urandom_range(0, 1) == 0) push_char(8'("g" + $urandom_range(0, 19)));
      else push_char(8'("A" + $urandom_range(0, 5)));
    end else if (pick < 85) begin
      push_char(op_chars[$urandom_range(0, op_chars.len() - 1)]);
    end else if (pick < 95) begin
      push_char(8'($urandom_range(0, 255)));
    end else begin
      push_char("#");
    end
    case ($urandom_range(0, 5))
      0, 1: push_char(" ");
      2:    push_char("\n");
      3:    push_char("\t");
      default: ;
    endcase
  endtask

  task automatic fill_random(int n);
    int first;
    first = chars_queued;
    while (chars_queued - first < n) add_word();
  endtask

  // Wait until every queued character is taken and every token is back.
  task automatic drain();
    while (chars_accepted != chars_queued || expected_tokens.size() != 0)
      @(posedge clk);
  endtask

  // Driver: a held character stays put until it is taken. Prediction runs on
  // the transaction itself, so the block's stall pattern never matters.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        scan_char(in_ch);
        chars_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (char_q.size() != 0 && !($urandom_range(0, 99) < send_idle_pct)) begin
          in_valid <= 1'b1;
          in_ch    <= char_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: each token transaction against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch($sformatf("token kind %0d start %0d with nothing expected",
                                    out_token_kind, out_token_start));
        end else begin
          want_tok = expected_tokens.pop_front();
          check_field("kind",     out_token_kind,   want_tok.kind);
          check_field("code",     out_token_code,   want_tok.code);
          check_field("start",    out_token_start,  want_tok.start);
          check_field("length",   out_token_length, want_tok.length);
          check_field("run_last", out_run_last,     want_tok.last);
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_scan();
    send_idle_pct  = 16;
    recv_stall_pct = 87;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: keyword then digit, hex, octal, bad zero, bad hex prefix,
    // lone zero, identifier, every operator, a high-bit byte, tab, end.
    push_text("do1+0x1f-017*08/0xg>0<A=(b2);");
    push_char(8'hFF);
    push_text("\t|#");
    fill_random(300);
    drain();

    send_idle_pct  = 87;
    recv_stall_pct = 16;
    fill_random(300);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fill_random(300);
    drain();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
